>>> design/polyev_pkg.sv
// ============================================================================
// Polynomial evaluator package
// Shared widths, register indexes and the stage-to-stage item type.
// ============================================================================
package polyev_pkg;

   localparam int MAX_DEGREE = 6;
   localparam int NUM_COEFS  = MAX_DEGREE + 1;

   localparam int DEG_W     = 3;
   localparam int COEF_W    = 16;
   localparam int X_W       = 16;
   localparam int ACC_W     = 32;
   localparam int PROD_W    = ACC_W + X_W;
   localparam int FRAC_BITS = 14;
   localparam int COEF_SHL  = 4;
   localparam int SUM_W     = PROD_W - FRAC_BITS + 1;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_0 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LAST = CSR_IDX_W'(NUM_COEFS);

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic [ACC_W-1:0] acc;
      logic [X_W-1:0]   x;
      logic             ovf;
   } link_type;

endpackage

>>> design/polyev_step.sv
// ============================================================================
// Polynomial evaluator Horner step
// One Horner step in two register stages: multiply, then scale, add the
// coefficient and saturate. An inactive step loads the coefficient instead.
// ============================================================================
module polyev_step (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [polyev_pkg::COEF_W-1:0] coef,
   input  logic                       active,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  polyev_pkg::link_type       in_link,
   output logic                       out_valid,
   input  logic                       out_ready,
   output polyev_pkg::link_type       out_link
);
   import polyev_pkg::*;

   logic              a_valid_ff;
   logic [PROD_W-1:0] a_prod_ff;
   logic [PROD_W-1:0] a_prod_in;
   logic [X_W-1:0]    a_x_ff;
   logic              a_ovf_ff;
   logic              a_ready;

   logic              b_valid_ff;
   link_type          b_link_ff;
   link_type          b_link_in;
   logic              b_ready;

   logic [SUM_W-1:0]  sum;
   logic              sat_pos;
   logic              sat_neg;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign a_prod_in = $signed({{X_W{in_link.acc[ACC_W-1]}}, in_link.acc})
                    * $signed({{ACC_W{in_link.x[X_W-1]}}, in_link.x});

   always_comb begin
      sum = $signed({a_prod_ff[PROD_W-1], a_prod_ff[PROD_W-1:FRAC_BITS]})
          + $signed({{(SUM_W-COEF_W-COEF_SHL){coef[COEF_W-1]}}, coef, {COEF_SHL{1'b0}}});
      sat_pos = !sum[SUM_W-1] && (|sum[SUM_W-2:ACC_W-1]);
      sat_neg = sum[SUM_W-1] && !(&sum[SUM_W-2:ACC_W-1]);
      b_link_in.x = a_x_ff;
      if (!active) begin
         b_link_in.acc = {{(ACC_W-COEF_W-COEF_SHL){coef[COEF_W-1]}}, coef, {COEF_SHL{1'b0}}};
         b_link_in.ovf = 1'b0;
      end else if (sat_pos) begin
         b_link_in.acc = ACC_MAX;
         b_link_in.ovf = 1'b1;
      end else if (sat_neg) begin
         b_link_in.acc = ACC_MIN;
         b_link_in.ovf = 1'b1;
      end else begin
         b_link_in.acc = sum[ACC_W-1:0];
         b_link_in.ovf = a_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         a_prod_ff <= a_prod_in;
         a_x_ff    <= in_link.x;
         a_ovf_ff  <= in_link.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_link_ff <= b_link_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_link  = b_link_ff;

endmodule

>>> design/polynomial_evaluator_core.sv
// ============================================================================
// Polynomial evaluator core
// Evaluates a configurable polynomial of up to sixth degree by Horner's rule.
// ============================================================================
// Each item on the req channel carries one sample x in signed Q2.14. The
// block answers each item with one item on the rsp channel that holds p(x)
// in signed Q16.16, saturated, and a flag that is set when any Horner step
// saturated. Items leave in the order they arrive.
// The degree and coefficients are written through the csr channel, which is
// always ready; they should be changed only while no item is in flight.
// Each Horner step takes two register stages (multiply, then add and
// saturate), and six such steps carry each item from acceptance to
// rsp_tvalid. One item is accepted every cycle while the output is taken.
// When the receiver stalls, each stage holds its item; stages that are empty
// still take new items, so req_tready falls only once the pipeline is full.
// Reset empties the pipeline and clears the degree and all coefficients.
// ============================================================================
module polynomial_evaluator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [polyev_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [polyev_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [polyev_pkg::REQ_DATA_W-1:0]  req_tdata,  // [15:0] sample_x
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [polyev_pkg::RSP_DATA_W-1:0]  rsp_tdata   // [31:0] poly_value,
                                                          // [32] overflow
);
   import polyev_pkg::*;

   logic [DEG_W-1:0]  degree_ff;
   logic [COEF_W-1:0] coef_ff [NUM_COEFS];
   logic [DEG_W-1:0]  deg_eff;

   logic              link_valid [MAX_DEGREE+1];
   logic              link_ready [MAX_DEGREE+1];
   link_type          link_data  [MAX_DEGREE+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '0;
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DEGREE) begin
            degree_ff <= csr_data[DEG_W-1:0];
         end
         for (int i = 0; i < NUM_COEFS; i++) begin
            if (csr_index == CSR_COEF_0 + CSR_IDX_W'(i)) begin
               coef_ff[i] <= csr_data[COEF_W-1:0];
            end
         end
      end
   end

   assign deg_eff = (degree_ff > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_ff;

   assign link_valid[MAX_DEGREE]    = req_tvalid;
   assign req_tready                = link_ready[MAX_DEGREE];
   assign link_data[MAX_DEGREE].acc = {{(ACC_W-COEF_W-COEF_SHL){coef_ff[MAX_DEGREE][COEF_W-1]}},
                                       coef_ff[MAX_DEGREE], {COEF_SHL{1'b0}}};
   assign link_data[MAX_DEGREE].x   = req_tdata[X_W-1:0];
   assign link_data[MAX_DEGREE].ovf = 1'b0;

   for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_step
      polyev_step u_step (
         .clock     (clock),
         .reset     (reset),
         .coef      (coef_ff[k]),
         .active    (DEG_W'(k) < deg_eff),
         .in_valid  (link_valid[k+1]),
         .in_ready  (link_ready[k+1]),
         .in_link   (link_data[k+1]),
         .out_valid (link_valid[k]),
         .out_ready (link_ready[k]),
         .out_link  (link_data[k])
      );
   end

   assign rsp_tvalid    = link_valid[0];
   assign link_ready[0] = rsp_tready;
   assign rsp_tdata     = {{(RSP_DATA_W-ACC_W-1){1'b0}}, link_data[0].ovf, link_data[0].acc};

`ifndef SYNTHESIS
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      link_valid[1] && !link_ready[1] |=> link_valid[1] && $stable(link_data[1]))
      else $error("stalled item changed between the last two steps");

   a_empty_output_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> link_ready[1])
      else $error("last step stalled with an empty output register");
`endif

endmodule

>>> test/tb_polynomial_evaluator_core.sv
// ============================================================================
// Testbench for the polynomial evaluator core
// Configures degree and coefficients through the csr channel, streams samples
// with random idle gaps on req and random stalls on rsp, and compares every
// result with a Horner evaluation computed in the bench at acceptance time.
// ============================================================================
module tb_polynomial_evaluator_core;
   import polyev_pkg::*;

   localparam longint VALUE_MAX   = 64'sd2147483647;
   localparam longint VALUE_MIN   = -64'sd2147483648;
   localparam int     QUIET_LIMIT = 1000;
   localparam int     SETTLE      = 16;
   localparam int     PHASES      = 17;
   localparam int     PHASE_ITEMS = 50;

   typedef struct packed {
      logic [X_W-1:0]   x_item;
      logic [ACC_W-1:0] poly_value;
      logic             overflow;
   } poly_result_type;

   class horner_tracker;
      logic [DEG_W-1:0]         degree;
      logic signed [COEF_W-1:0] coefs [NUM_COEFS];
      poly_result_type          pending_results [$];
      int                       errors;

      function new();
         degree = '0;
         foreach (coefs[k]) coefs[k] = '0;
         errors = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_DEGREE) begin
            degree = data[DEG_W-1:0];
         end else if (idx >= CSR_COEF_0 && idx <= CSR_COEF_LAST) begin
            coefs[idx - CSR_COEF_0] = data;
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void note_sample(logic [X_W-1:0] x_bits);
         logic signed [X_W-1:0] x;
         longint                acc;
         longint                prod;
         longint                total;
         int                    top;
         poly_result_type       r;
         x = x_bits;
         top = (int'(degree) > MAX_DEGREE) ? MAX_DEGREE : int'(degree);
         r.x_item = x_bits;
         r.overflow = 1'b0;
         acc = longint'(coefs[top]) * 16;
         for (int k = top - 1; k >= 0; k--) begin
            prod = acc * longint'(x);
            total = (prod >>> FRAC_BITS) + longint'(coefs[k]) * 16;
            if (total > VALUE_MAX) begin
               acc = VALUE_MAX;
               r.overflow = 1'b1;
            end else if (total < VALUE_MIN) begin
               acc = VALUE_MIN;
               r.overflow = 1'b1;
            end else begin
               acc = total;
            end
         end
         r.poly_value = 32'(acc);
         pending_results.push_back(r);
      endfunction

      task report(string msg);
         if (errors < 40) begin
            $display("tb_polynomial_evaluator_core: mismatch: %s", msg);
         end
         errors++;
      endtask

      task check_result(logic [RSP_DATA_W-1:0] data);
         poly_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("result %h arrived with no sample pending", data));
            return;
         end
         want = pending_results.pop_front();
         if (data[ACC_W-1:0] !== want.poly_value) begin
            report($sformatf("x=%h poly_value %h, expected %h",
                             want.x_item, data[ACC_W-1:0], want.poly_value));
         end
         if (data[ACC_W] !== want.overflow) begin
            report($sformatf("x=%h overflow %b, expected %b",
                             want.x_item, data[ACC_W], want.overflow));
         end
         if (data[RSP_DATA_W-1:ACC_W+1] !== '0) begin
            report($sformatf("x=%h padding bits %h not zero",
                             want.x_item, data[RSP_DATA_W-1:ACC_W+1]));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   horner_tracker tracker;
   bit            req_idles;
   bit            rsp_stalls;
   int            quiet_cycles = 0;

   polynomial_evaluator_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function int idle_cycles();
      if ($urandom_range(0, 9) < 8) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 40);
   endfunction

   function int sample_gap();
      if (!req_idles || $urandom_range(0, 99) < 60) begin
         return 0;
      end
      return idle_cycles();
   endfunction

   function logic [X_W-1:0] pick_x();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h4000;
            default: return 16'hC000;
         endcase
      end
      if (r < 5) begin
         return X_W'($urandom_range(0, 32768) - 16384);
      end
      return X_W'($urandom);
   endfunction

   function logic [CSR_DATA_W-1:0] pick_coef(int mode);
      case (mode)
         0: return CSR_DATA_W'($urandom);
         1: return CSR_DATA_W'($urandom_range(0, 8192) - 4096);
         default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      endcase
   endfunction

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(idx, data);
   endtask

   task load_uniform(logic [CSR_DATA_W-1:0] deg_data, logic [CSR_DATA_W-1:0] coef);
      write_csr(CSR_DEGREE, deg_data);
      for (int k = 0; k < NUM_COEFS; k++) begin
         write_csr(CSR_IDX_W'(CSR_COEF_0 + k), coef);
      end
      csr_valid <= 1'b0;
   endtask

   task load_random_config();
      logic [CSR_DATA_W-1:0] deg_data;
      int                    mode;
      deg_data = CSR_DATA_W'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) begin
         deg_data[CSR_DATA_W-1:DEG_W] = (CSR_DATA_W - DEG_W)'($urandom);
      end
      mode = $urandom_range(0, 2);
      write_csr(CSR_DEGREE, deg_data);
      for (int k = 0; k < NUM_COEFS; k++) begin
         write_csr(CSR_IDX_W'(CSR_COEF_0 + k), pick_coef(mode));
      end
      if ($urandom_range(0, 3) == 0) begin
         write_csr(CSR_IDX_W'($urandom_range(NUM_COEFS + 1, (1 << CSR_IDX_W) - 1)),
                   CSR_DATA_W'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   task send_sample(logic [X_W-1:0] x);
      int gap;
      gap = sample_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (!req_tready);
      tracker.note_sample(x);
   endtask

   task send_list(logic [X_W-1:0] xs [$]);
      foreach (xs[i]) send_sample(xs[i]);
   endtask

   task drain();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (rsp_stalls) begin
            rsp_tready <= 1'b0;
            repeat (idle_cycles()) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_result(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_polynomial_evaluator_core: no handshake for %0d cycles", QUIET_LIMIT);
         $display("tb_polynomial_evaluator_core: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      tracker    = new();
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_idles  = 1'b1;
      rsp_stalls = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Degree zero with upper data bits set; higher coefficients must not matter.
      load_uniform(16'hFFF8, 16'h7FFF);
      send_list({16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF});
      drain();
      write_csr(CSR_COEF_0, 16'h8000);
      csr_valid <= 1'b0;
      send_list({16'h4000});
      drain();

      // Degree seven behaves as six; full-scale coefficients drive saturation.
      load_uniform(16'h0007, 16'h7FFF);
      send_list({16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h0001});
      drain();
      load_uniform(16'h0006, 16'h8000);
      send_list({16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000});
      drain();

      // Small negative products must round toward minus infinity. Writes to
      // indexes past the last coefficient are ignored.
      load_uniform(16'h0001, 16'h0000);
      write_csr(CSR_IDX_W'(CSR_COEF_0 + 1), 16'hFFFF);
      write_csr(CSR_IDX_W'(CSR_COEF_LAST + 1), 16'h7FFF);
      write_csr('1, 16'h7FFF);
      csr_valid <= 1'b0;
      send_list({16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF});
      drain();

      for (int p = 0; p < PHASES; p++) begin
         req_idles  = $urandom_range(0, 3) != 0;
         rsp_stalls = $urandom_range(0, 3) != 0;
         load_random_config();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_sample(pick_x());
         end
         drain();
      end

      if (tracker.errors == 0) begin
         $display("tb_polynomial_evaluator_core: done, clean");
      end else begin
         $display("tb_polynomial_evaluator_core: done, errors");
      end
      $finish;
   end
endmodule

>>> files.f
design/polyev_pkg.sv
design/polyev_step.sv
design/polynomial_evaluator_core.sv
test/tb_polynomial_evaluator_core.sv
